FILE: design/gbrm_pkg.sv
package gbrm_pkg;

  // Input item kinds carried on s_tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_RADIUS  = 3'd0;
  localparam logic [2:0] REG_WIDTH   = 3'd1;
  localparam logic [2:0] REG_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_WEIGHT0 = 3'd3;
  localparam logic [2:0] REG_WEIGHT4 = 3'd7;

  localparam int NUM_WEIGHTS = 5;
  localparam int CW          = 12;  // signed tap coordinate width
  localparam int ACC_W       = 48;  // up to 15x15 taps of 8x32-bit products
  localparam int PROD_W      = 40;

  localparam logic [7:0] CHAN_MAX = 8'd255;
  localparam logic [7:0] CHAN_MIN = 8'd0;

  typedef logic [NUM_WEIGHTS-1:0][15:0] weight_set_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tap_ctrl_t;

  // Mirror a tap coordinate into 0..size-1 without repeating the edge pixel.
  function automatic logic [8:0] fold(input logic signed [CW-1:0] c_in,
                                      input logic [8:0] size);
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
    c = c_in;
    s = $signed({{(CW-9){1'b0}}, size});
    if (c < 0) c = -c;
    if (c >= s) c = (s <<< 1) - CW'(2) - c;
    if (c < 0) c = '0;
    if (c >= s) c = s - CW'(1);
    return c[8:0];
  endfunction

  // One-dimensional weight at distance d; distances above four weigh nothing.
  function automatic logic [15:0] weight_of(input weight_set_t ws, input logic [2:0] d);
    logic [15:0] w;
    w = '0;
    if (d < 3'(NUM_WEIGHTS)) w = ws[d];
    return w;
  endfunction

endpackage

FILE: design/gbrm_frame_mem.sv
module gbrm_frame_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [23:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [23:0]   rd_data
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/gbrm_tap_seq.sv
module gbrm_tap_seq #(
  parameter int MAX_WIDTH = 256,
  parameter int AW        = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [7:0]           x_pos,
  input  logic [7:0]           y_pos,
  input  logic [2:0]           radius,
  input  logic [8:0]           width,
  input  logic [8:0]           height,
  input  gbrm_pkg::weight_set_t weights,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  output logic [31:0]          wt,
  output gbrm_pkg::tap_ctrl_t  ctrl,
  output logic                 busy
);
  import gbrm_pkg::*;

  logic              running;
  logic signed [3:0] dx, dy;
  logic [7:0]        x_base, y_base;
  logic [2:0]        r_lat;

  logic signed [3:0]    r_s;
  logic signed [CW-1:0] cx, cy;
  logic [8:0]           tx, ty;
  logic [2:0]           adx, ady;
  logic [31:0]          wt_next;
  logic                 last_tap;

  assign r_s      = $signed({1'b0, r_lat});
  assign cx       = $signed({{(CW-8){1'b0}}, x_base}) + CW'(dx);
  assign cy       = $signed({{(CW-8){1'b0}}, y_base}) + CW'(dy);
  assign tx       = fold(cx, width);
  assign ty       = fold(cy, height);
  assign adx      = (dx < 0) ? 3'(-dx) : 3'(dx);
  assign ady      = (dy < 0) ? 3'(-dy) : 3'(dy);
  assign wt_next  = {16'b0, weight_of(weights, adx)} * {16'b0, weight_of(weights, ady)};
  assign last_tap = (dx == r_s) && (dy == r_s);

  assign rd_en   = running;
  assign rd_addr = AW'(32'(ty) * MAX_WIDTH + 32'(tx));
  assign busy    = running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      ctrl    <= '0;
    end else begin
      ctrl.valid <= running;
      ctrl.last  <= running && last_tap;
      if (start) begin
        running <= 1'b1;
      end else if (running && last_tap) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wt <= wt_next;
    if (start) begin
      x_base <= x_pos;
      y_base <= y_pos;
      r_lat  <= radius;
      dx     <= -$signed({1'b0, radius});
      dy     <= -$signed({1'b0, radius});
    end else if (running) begin
      if (dx == r_s) begin
        dx <= -r_s;
        dy <= dy + 4'sd1;
      end else begin
        dx <= dx + 4'sd1;
      end
    end
  end

endmodule

FILE: design/gbrm_mac.sv
module gbrm_mac (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic [23:0]         pixel,
  input  logic [31:0]         wt,
  input  gbrm_pkg::tap_ctrl_t ctrl,
  output logic                done,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue
);
  import gbrm_pkg::*;

  logic [PROD_W-1:0] prod_r, prod_g, prod_b;
  tap_ctrl_t         pctrl;
  logic [ACC_W-1:0]  acc_r, acc_g, acc_b;

  function automatic logic [7:0] clamp(input logic [ACC_W-1:0] a);
    logic [7:0] v;
    v = (a[ACC_W-1:32] > (ACC_W-32)'(CHAN_MAX)) ? CHAN_MAX : a[39:32];
    return v;
  endfunction

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(pixel[23:16]) * PROD_W'(wt);
    prod_g <= PROD_W'(pixel[15:8]) * PROD_W'(wt);
    prod_b <= PROD_W'(pixel[7:0]) * PROD_W'(wt);
    if (clear) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (pctrl.valid) begin
      acc_r <= acc_r + ACC_W'(prod_r);
      acc_g <= acc_g + ACC_W'(prod_g);
      acc_b <= acc_b + ACC_W'(prod_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pctrl <= '0;
      done  <= 1'b0;
    end else begin
      pctrl <= ctrl;
      done  <= pctrl.valid && pctrl.last;
    end
  end

  assign red   = clamp(acc_r);
  assign green = clamp(acc_g);
  assign blue  = clamp(acc_b);

endmodule

FILE: design/gaussian_blur_rgb_mirror_border.sv
// Channel   Direction  Width  Contents
// s_*       in         40+1   tdata: x_pos, y_pos, in_red, in_green, in_blue; tuser: command
// m_*       out        24+1   tdata: out_red, out_green, out_blue; tuser: coord_error
// cfg_*     in         3+16   register index and write data
//
// A pixel write inside the frame gives no result. A query walks (2R+1)^2 kernel taps,
// one frame memory read per cycle on the single read port, and its result passes through
// the memory read register, the product registers and the accumulator before ST_DONE loads
// it into the output register. An out-of-frame item goes straight to ST_DONE with an error result.
// Reset clears control state and loads the register defaults; the frame store is not
// cleared. A stalled output holds its result while the next item is accepted.
module gaussian_blur_rgb_mirror_border #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream: tdata holds x_pos[7:0], y_pos[15:8], in_red[23:16], in_green[31:24],
  // in_blue[39:32]; tuser holds command.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tuser,
  // Result stream: tdata holds out_red[7:0], out_green[15:8], out_blue[23:16];
  // tuser holds coord_error.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tuser,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);
  import gbrm_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Configuration registers.
  logic [2:0]  kernel_radius;
  logic [8:0]  image_width;
  logic [8:0]  image_height;
  weight_set_t weights;

  logic [1:0]  state;
  logic        res_err;

  // Input fields.
  logic       command;
  logic [7:0] x_pos, y_pos, in_red, in_green, in_blue;
  assign command  = s_tuser;
  assign x_pos    = s_tdata[7:0];
  assign y_pos    = s_tdata[15:8];
  assign in_red   = s_tdata[23:16];
  assign in_green = s_tdata[31:24];
  assign in_blue  = s_tdata[39:32];

  // Sizes and radius saturated to what the storage and the taps allow.
  logic [8:0] w_eff, h_eff;
  logic [2:0] r_eff;
  assign w_eff = (32'(image_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : image_width;
  assign h_eff = (32'(image_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : image_height;
  assign r_eff = (32'(kernel_radius) > MAX_RADIUS) ? 3'(MAX_RADIUS) : kernel_radius;

  logic in_xfer, outside, do_write, do_query, out_free;
  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign outside  = !({1'b0, x_pos} < w_eff) || !({1'b0, y_pos} < h_eff);
  assign do_write = in_xfer && !outside && (command == CMD_WRITE);
  assign do_query = in_xfer && !outside && (command == CMD_QUERY);
  assign out_free = !m_tvalid || m_tready;

  // Tap sequencer, frame memory and accumulator.
  logic            rd_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [23:0]     rd_data;
  logic [31:0]     wt;
  tap_ctrl_t       tap_ctrl;
  logic            seq_busy;
  logic            mac_done;
  logic [7:0]      f_red, f_green, f_blue;

  assign wr_addr = AW'(32'(y_pos) * MAX_WIDTH + 32'(x_pos));

  gbrm_tap_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (do_query),
    .x_pos   (x_pos),
    .y_pos   (y_pos),
    .radius  (r_eff),
    .width   (w_eff),
    .height  (h_eff),
    .weights (weights),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wt      (wt),
    .ctrl    (tap_ctrl),
    .busy    (seq_busy)
  );

  gbrm_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (wr_addr),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gbrm_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .clear (do_query),
    .pixel (rd_data),
    .wt    (wt),
    .ctrl  (tap_ctrl),
    .done  (mac_done),
    .red   (f_red),
    .green (f_green),
    .blue  (f_blue)
  );

  // Configuration is always ready; software must write only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_radius <= 3'd1;
      image_width   <= 9'd256;
      image_height  <= 9'd256;
      weights       <= {16'd0, 16'd0, 16'd0, 16'd16384, 16'd32768};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr) inside
        REG_RADIUS:                kernel_radius <= cfg_data[2:0];
        REG_WIDTH:                 image_width   <= cfg_data[8:0];
        REG_HEIGHT:                image_height  <= cfg_data[8:0];
        [REG_WEIGHT0:REG_WEIGHT4]: weights[3'(cfg_addr - REG_WEIGHT0)] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item control: a query runs until the accumulator reports its last tap, an out-of-frame
  // item skips ST_RUN, and either result waits in ST_DONE until the output register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && outside) begin
            state <= ST_DONE;
          end else if (do_query) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (mac_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_err <= outside;
    end
    if (state == ST_DONE && out_free) begin
      m_tuser <= res_err;
      m_tdata <= res_err ? {CHAN_MIN, CHAN_MIN, CHAN_MIN} : {f_blue, f_green, f_red};
    end
  end

  // The accumulator finishes only for a query in progress.
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == ST_RUN))
    else $error("accumulator finished outside a running query");

  // The tap walk never outlives the query that started it.
  a_seq_in_run: assert property (@(posedge clk) disable iff (rst)
    seq_busy |-> (state == ST_RUN))
    else $error("tap sequencer busy outside a running query");

  // An out-of-frame item goes straight to a pending error result.
  a_err_path: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && outside) |=> (state == ST_DONE && res_err))
    else $error("out-of-frame item did not raise an error result");

endmodule
